>>> rtl/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants of the coordinate slot accumulator
// Action and status codes, the probe word that walks the slot chain, and the
// saturating Q32.16 add used by every slot.
// ----------------------------------------------------------------------------
package csa_pkg;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_ACCUM  = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam int SLOT_W = 8;
   localparam int SUM_W  = 48;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

   // Word that travels down the slot chain with one request.
   typedef struct packed {
      logic [1:0]               action;
      logic [15:0]              row;
      logic [15:0]              col;
      logic signed [31:0]       value;
      logic                     hit;
      logic [1:0]               status;
      logic signed [SUM_W-1:0]  sum;
   } probe_type;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [31:0]      b
   );
      logic [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {{(SUM_W-31){b[31]}}, b};
      if (s[SUM_W:SUM_W-1] == 2'b01) begin
         return SUM_MAX;
      end else if (s[SUM_W:SUM_W-1] == 2'b10) begin
         return SUM_MIN;
      end else begin
         return s[SUM_W-1:0];
      end
   endfunction

endpackage

>>> rtl/csa_cell.sv
// ----------------------------------------------------------------------------
// csa_cell: one slot of the coordinate table
// Holds the key pair and running sum of its slot. Compares, inserts,
// accumulates or clears as the probe word passes, then hands it on.
// ----------------------------------------------------------------------------
module csa_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 8,
   parameter int CNT_W = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [CNT_W-1:0]      in_left,
   input  logic [IDX_W-1:0]      in_slot,
   input  csa_pkg::probe_type    in_probe,
   output logic                  out_valid,
   output logic [CNT_W-1:0]      out_left,
   output logic [IDX_W-1:0]      out_slot,
   output csa_pkg::probe_type    out_probe
);

   localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(INDEX);

   logic [15:0]                       row_ff, row_in;
   logic [15:0]                       col_ff, col_in;
   logic signed [csa_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                              valid_ff;
   logic [CNT_W-1:0]                  left_ff, left_in;
   logic [IDX_W-1:0]                  slot_ff, slot_in;
   csa_pkg::probe_type                probe_ff, probe_in;

   logic                              used;
   logic                              match;
   logic signed [csa_pkg::SUM_W-1:0]  acc;

   // Slots below the fill count are in use; the count left rides along.
   assign used  = (in_left != '0);
   assign match = used && (row_ff == in_probe.row) && (col_ff == in_probe.col);
   assign acc   = csa_pkg::sat_add(sum_ff, in_probe.value);

   always_comb begin
      probe_in = in_probe;
      slot_in  = in_slot;
      left_in  = used ? (in_left - CNT_W'(1)) : in_left;
      row_in   = row_ff;
      col_in   = col_ff;
      sum_in   = sum_ff;
      if (in_valid && !in_probe.hit) begin
         case (in_probe.action)
            csa_pkg::ACT_INSERT: begin
               if (match) begin
                  probe_in.hit    = 1'b1;
                  probe_in.status = csa_pkg::ST_PRESENT;
                  slot_in         = MY_SLOT;
               end else if (!used) begin
                  // first free slot: every used slot has been checked already
                  row_in          = in_probe.row;
                  col_in          = in_probe.col;
                  sum_in          = '0;
                  probe_in.hit    = 1'b1;
                  probe_in.status = csa_pkg::ST_OK;
                  slot_in         = MY_SLOT;
               end
            end
            csa_pkg::ACT_ACCUM: begin
               if (match) begin
                  sum_in          = acc;
                  probe_in.hit    = 1'b1;
                  probe_in.status = csa_pkg::ST_OK;
                  probe_in.sum    = acc;
                  slot_in         = MY_SLOT;
               end
            end
            csa_pkg::ACT_CLEAR: begin
               if (used) begin
                  sum_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      left_ff  <= left_in;
      slot_ff  <= slot_in;
      probe_ff <= probe_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      sum_ff   <= sum_in;
   end

   assign out_valid = valid_ff;
   assign out_left  = left_ff;
   assign out_slot  = slot_ff;
   assign out_probe = probe_ff;

endmodule

>>> rtl/coordinate_slot_accumulator.sv
// ----------------------------------------------------------------------------
// coordinate_slot_accumulator: sparse-matrix coordinate table
// Top level: request/response handshakes, fill count and the slot chain.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word: action (insert, accumulate, clear), row, col and
//   a signed Q16.16 value. rsp_* returns one word per request: slot, status
//   and the saturated Q32.16 sum (zero unless an accumulate hit).
//   A request walks the chain of ENTRIES slot cells, one cell per cycle, and
//   its response is registered at the end. One request is in flight at a
//   time, so a new word is taken only once the response has been taken;
//   the chain length is what sets the rate of words.
//   Reset empties the table (fill count zero) and drops any request in
//   flight; slot contents need no clearing.
//   While the receiver holds rsp_ready low the response stays put and
//   req_ready stays low.
// ----------------------------------------------------------------------------
module coordinate_slot_accumulator #(
   parameter int ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [15:0]                       req_row,
   input  logic [15:0]                       req_col,
   input  logic signed [31:0]                req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [csa_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [1:0]                        rsp_status,
   output logic signed [csa_pkg::SUM_W-1:0]  rsp_sum
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [ENTRIES:0]    chain_valid;
   logic [CNT_W-1:0]    chain_left  [ENTRIES+1];
   logic [IDX_W-1:0]    chain_slot  [ENTRIES+1];
   csa_pkg::probe_type  chain_probe [ENTRIES+1];

   logic                              busy_ff, busy_in;
   logic [CNT_W-1:0]                  used_ff, used_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [csa_pkg::SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [1:0]                        rsp_status_ff, rsp_status_in;
   logic signed [csa_pkg::SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;

   logic                req_take;
   logic                done;
   csa_pkg::probe_type  head_probe;
   csa_pkg::probe_type  tail_probe;

   assign req_ready = !busy_ff && !rsp_valid_ff;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      head_probe.action = req_action;
      head_probe.row    = req_row;
      head_probe.col    = req_col;
      head_probe.value  = req_value;
      head_probe.hit    = 1'b0;
      head_probe.sum    = '0;
      // status left here stands when no slot resolves the request
      case (req_action)
         csa_pkg::ACT_INSERT: head_probe.status = csa_pkg::ST_FULL;
         csa_pkg::ACT_ACCUM:  head_probe.status = csa_pkg::ST_MISSING;
         default:             head_probe.status = csa_pkg::ST_OK;
      endcase
   end

   assign chain_valid[0] = req_take;
   assign chain_left[0]  = used_ff;
   assign chain_slot[0]  = '0;
   assign chain_probe[0] = head_probe;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_slot
      csa_cell #(
         .INDEX (k),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_left   (chain_left[k]),
         .in_slot   (chain_slot[k]),
         .in_probe  (chain_probe[k]),
         .out_valid (chain_valid[k+1]),
         .out_left  (chain_left[k+1]),
         .out_slot  (chain_slot[k+1]),
         .out_probe (chain_probe[k+1])
      );
   end

   assign done       = chain_valid[ENTRIES];
   assign tail_probe = chain_probe[ENTRIES];

   always_comb begin
      busy_in       = busy_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sum_in    = rsp_sum_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_take) begin
         busy_in = 1'b1;
      end
      if (done) begin
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = tail_probe.hit ? csa_pkg::SLOT_W'(chain_slot[ENTRIES]) : '0;
         rsp_status_in = tail_probe.status;
         rsp_sum_in    = tail_probe.sum;
         // advance the fill count on a fresh insert
         if (tail_probe.action == csa_pkg::ACT_INSERT && tail_probe.hit &&
             tail_probe.status == csa_pkg::ST_OK) begin
            used_in = used_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sum_ff    <= rsp_sum_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_sum    = rsp_sum_ff;

`ifndef SYNTHESIS
   a_single_probe : assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one request in the slot chain");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond table depth");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      done |-> !rsp_valid_ff)
      else $error("chain result arrived while a response was pending");

   a_done_busy : assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("chain result without a request in flight");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != csa_pkg::ST_OK &&
       rsp_status_ff != csa_pkg::ST_PRESENT) |-> (rsp_sum_ff == '0 && rsp_slot_ff == '0))
      else $error("refused request returned a nonzero slot or sum");
`endif

endmodule

>>> bench/coordinate_slot_accumulator_tb.sv
// ----------------------------------------------------------------------------
// coordinate_slot_accumulator_tb: self-checking bench for the coordinate table
// Drives insert, accumulate, clear and unused-action words through the
// request channel with random idle gaps on both sides. A behavioral copy of
// the table predicts slot, status and saturated sum for every accepted word;
// each response is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module coordinate_slot_accumulator_tb;

   localparam int TABLE_DEPTH = 256;
   localparam logic [1:0] ACT_NONE = 2'd3;
   // chain walk plus registered response
   localparam int LATENCY     = TABLE_DEPTH + 2;
   localparam int CYCLE_LIMIT = 1_500_000;

   typedef struct {
      logic [csa_pkg::SLOT_W-1:0]       slot;
      logic [1:0]                       status;
      logic signed [csa_pkg::SUM_W-1:0] sum;
   } reply_word_type;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_valid  = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_action = csa_pkg::ACT_INSERT;
   logic [15:0]                      req_row    = '0;
   logic [15:0]                      req_col    = '0;
   logic signed [31:0]               req_value  = '0;
   logic                             rsp_valid;
   logic                             rsp_ready  = 1'b0;
   logic [csa_pkg::SLOT_W-1:0]       rsp_slot;
   logic [1:0]                       rsp_status;
   logic signed [csa_pkg::SUM_W-1:0] rsp_sum;

   // behavioral copy of the table
   logic [15:0]                      pair_rows [TABLE_DEPTH];
   logic [15:0]                      pair_cols [TABLE_DEPTH];
   logic signed [csa_pkg::SUM_W-1:0] pair_sums [TABLE_DEPTH];
   int unsigned                      pairs_used = 0;

   reply_word_type expected_replies [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned tx_calm     = 0;
   int unsigned rx_calm     = 0;

   coordinate_slot_accumulator #(.ENTRIES(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status),
      .rsp_sum    (rsp_sum)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Draw a random idle gap, or none during occasional stretches of back-to-back words.
   function automatic int draw_wait(inout int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 5);
   endfunction

   function automatic logic signed [31:0] rand_value();
      if ($urandom_range(0, 3) == 0) begin
         return 32'($urandom_range(0, 511)) - 32'sd256;
      end
      return $urandom;
   endfunction

   function automatic int find_pair(input logic [15:0] r, input logic [15:0] c);
      for (int k = 0; k < pairs_used; k++) begin
         if (pair_rows[k] == r && pair_cols[k] == c) begin
            return k;
         end
      end
      return -1;
   endfunction

   // Update the table copy for one word and return the response it causes.
   function automatic reply_word_type assemble_entry(input logic [1:0] act,
                                                     input logic [15:0] r,
                                                     input logic [15:0] c,
                                                     input logic signed [31:0] v);
      reply_word_type rep;
      int             k;
      longint         acc;
      rep.slot   = '0;
      rep.status = csa_pkg::ST_OK;
      rep.sum    = '0;
      k = find_pair(r, c);
      case (act)
         csa_pkg::ACT_INSERT: begin
            if (k >= 0) begin
               rep.status = csa_pkg::ST_PRESENT;
               rep.slot   = csa_pkg::SLOT_W'(k);
            end else if (pairs_used >= TABLE_DEPTH) begin
               rep.status = csa_pkg::ST_FULL;
            end else begin
               rep.slot              = csa_pkg::SLOT_W'(pairs_used);
               pair_rows[pairs_used] = r;
               pair_cols[pairs_used] = c;
               pair_sums[pairs_used] = '0;
               pairs_used++;
            end
         end
         csa_pkg::ACT_ACCUM: begin
            if (k < 0) begin
               rep.status = csa_pkg::ST_MISSING;
            end else begin
               acc = longint'(pair_sums[k]) + longint'(v);
               if (acc > longint'(csa_pkg::SUM_MAX)) acc = longint'(csa_pkg::SUM_MAX);
               if (acc < longint'(csa_pkg::SUM_MIN)) acc = longint'(csa_pkg::SUM_MIN);
               pair_sums[k] = csa_pkg::SUM_W'(acc);
               rep.slot     = csa_pkg::SLOT_W'(k);
               rep.sum      = csa_pkg::SUM_W'(acc);
            end
         end
         csa_pkg::ACT_CLEAR: begin
            for (int i = 0; i < pairs_used; i++) begin
               pair_sums[i] = '0;
            end
         end
         default: begin
         end
      endcase
      return rep;
   endfunction

   task automatic pick_used_pair(output logic [15:0] r, output logic [15:0] c);
      int k;
      if (pairs_used == 0) begin
         r = 16'($urandom);
         c = 16'($urandom);
      end else begin
         k = $urandom_range(0, pairs_used - 1);
         r = pair_rows[k];
         c = pair_cols[k];
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Send one word; valid stays up across back-to-back words.
   task automatic send_word(input logic [1:0] act, input logic [15:0] r,
                            input logic [15:0] c, input logic signed [31:0] v);
      int             gap;
      reply_word_type rep;
      gap = draw_wait(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_action <= act;
      req_row    <= r;
      req_col    <= c;
      req_value  <= v;
      req_valid  <= 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      rep = assemble_entry(act, r, c, v);
      expected_replies.insert(expected_replies.size(), rep);
   endtask

   task automatic check_reply();
      reply_word_type want;
      if (expected_replies.size() == 0) begin
         report_mismatch($sformatf("response with nothing pending: slot %0d status %0d sum %0d",
                                   rsp_slot, rsp_status, rsp_sum));
      end else begin
         want = expected_replies.pop_front();
         if (rsp_slot !== want.slot)
            report_mismatch($sformatf("slot got %0d want %0d", rsp_slot, want.slot));
         if (rsp_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
         if (rsp_sum !== want.sum)
            report_mismatch($sformatf("sum got %0d want %0d", rsp_sum, want.sum));
      end
   endtask

   // Response side: stall either before the word shows up or while it waits.
   initial begin : reply_checker
      int stall;
      forever begin
         stall = draw_wait(rx_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
               @(posedge clock);
               while (rsp_valid !== 1'b1) @(posedge clock);
               repeat (stall - 1) @(posedge clock);
            end else begin
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         check_reply();
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic test_edge_pairs();
      send_word(csa_pkg::ACT_INSERT, 16'h0000, 16'h0000, 32'sh0);
      send_word(csa_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFF, 32'shFFFF_FFFF);
      send_word(csa_pkg::ACT_INSERT, 16'h0000, 16'hFFFF, 32'sh0);
      send_word(csa_pkg::ACT_INSERT, 16'hFFFF, 16'h0000, 32'sh0);
      // duplicate insert reports the owning slot
      send_word(csa_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFF, 32'sh0);
      send_word(csa_pkg::ACT_ACCUM, 16'h0000, 16'h0000, 32'sh7FFF_FFFF);
      send_word(csa_pkg::ACT_ACCUM, 16'h0000, 16'h0000, 32'sh7FFF_FFFF);
      send_word(csa_pkg::ACT_ACCUM, 16'hFFFF, 16'hFFFF, 32'sh8000_0000);
      send_word(csa_pkg::ACT_ACCUM, 16'hFFFF, 16'hFFFF, 32'sh8000_0000);
      send_word(csa_pkg::ACT_ACCUM, 16'h0000, 16'hFFFF, 32'shFFFF_FFFF);
      // missing pairs, one sharing a row with a stored pair
      send_word(csa_pkg::ACT_ACCUM, 16'h0001, 16'h0001, 32'sh1234_5678);
      send_word(csa_pkg::ACT_ACCUM, 16'h0000, 16'h0001, 32'sh0000_0001);
      send_word(ACT_NONE, 16'($urandom), 16'($urandom), $urandom);
      send_word(ACT_NONE, 16'hFFFF, 16'hFFFF, 32'shFFFF_FFFF);
      send_word(csa_pkg::ACT_CLEAR, 16'($urandom), 16'($urandom), $urandom);
      send_word(csa_pkg::ACT_ACCUM, 16'h0000, 16'h0000, 32'sh0000_0001);
      send_word(csa_pkg::ACT_INSERT, 16'h0000, 16'h0000, 32'sh0);
      send_word(csa_pkg::ACT_ACCUM, 16'hFFFF, 16'h0000, 32'sh0);
   endtask

   task automatic test_mixed_traffic(input int count);
      int          sel;
      logic [15:0] r;
      logic [15:0] c;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         r   = 16'($urandom);
         c   = 16'($urandom);
         if (sel < 20) begin
            send_word(csa_pkg::ACT_INSERT, r, c, $urandom);
         end else if (sel < 28) begin
            pick_used_pair(r, c);
            send_word(csa_pkg::ACT_INSERT, r, c, $urandom);
         end else if (sel < 75) begin
            pick_used_pair(r, c);
            send_word(csa_pkg::ACT_ACCUM, r, c, rand_value());
         end else if (sel < 82) begin
            send_word(csa_pkg::ACT_ACCUM, r, c, rand_value());
         end else if (sel < 90) begin
            // near miss: flip one bit of a stored pair
            pick_used_pair(r, c);
            if ($urandom_range(0, 1) == 1) r ^= 16'(1) << $urandom_range(0, 15);
            else c ^= 16'(1) << $urandom_range(0, 15);
            send_word(csa_pkg::ACT_ACCUM, r, c, rand_value());
         end else if (sel < 95) begin
            send_word(csa_pkg::ACT_CLEAR, r, c, $urandom);
         end else begin
            send_word(ACT_NONE, r, c, $urandom);
         end
      end
   endtask

   task automatic test_fill_table();
      while (pairs_used < TABLE_DEPTH) begin
         send_word(csa_pkg::ACT_INSERT, 16'($urandom), 16'($urandom), $urandom);
         if ($urandom_range(0, 3) == 0) begin
            send_word(csa_pkg::ACT_ACCUM, pair_rows[pairs_used-1],
                      pair_cols[pairs_used-1], rand_value());
         end
      end
   endtask

   task automatic test_full_table();
      send_word(csa_pkg::ACT_INSERT, 16'($urandom), 16'($urandom), $urandom);
      send_word(csa_pkg::ACT_INSERT, pair_rows[TABLE_DEPTH-1], pair_cols[TABLE_DEPTH-1],
                $urandom);
      send_word(csa_pkg::ACT_ACCUM, pair_rows[TABLE_DEPTH-1], pair_cols[TABLE_DEPTH-1],
                32'sh7FFF_FFFF);
      send_word(csa_pkg::ACT_CLEAR, 16'($urandom), 16'($urandom), $urandom);
      send_word(csa_pkg::ACT_ACCUM, pair_rows[TABLE_DEPTH-1], pair_cols[TABLE_DEPTH-1],
                32'sh8000_0000);
      test_mixed_traffic(290);
   endtask

   initial begin : run_tests
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_edge_pairs();
      test_mixed_traffic(450);
      test_fill_table();
      test_full_table();
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/csa_pkg.sv
rtl/csa_cell.sv
rtl/coordinate_slot_accumulator.sv
bench/coordinate_slot_accumulator_tb.sv
